[rtl/ect_pkg.sv]
// entity component table engine: shared codes, field widths and types
// no dependencies; used by the interfaces, the request checker and the top level
package ect_pkg;

  // field widths of the request, result and configuration beats
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned ENT_W   = 10;
  localparam int unsigned TYPE_W  = 6;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned MASK_W  = 64;
  localparam int unsigned CFGA_W  = 4;
  localparam int unsigned CFGD_W  = 16;
  localparam int unsigned TIU_W   = 7;
  localparam int unsigned LIM_W   = 11;

  // request codes
  localparam logic [REQ_W-1:0] REQ_CREATE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_ADD    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_GET    = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
  localparam logic [STAT_W-1:0] ST_ENT_ABSENT  = 3'd1;
  localparam logic [STAT_W-1:0] ST_COMP_ABSENT = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL        = 3'd3;
  localparam logic [STAT_W-1:0] ST_RANGE       = 3'd4;

  // configuration register indexes
  localparam logic [CFGA_W-1:0] CFG_TYPES_IN_USE = 4'd0;
  localparam logic [CFGA_W-1:0] CFG_ENTITY_LIMIT = 4'd1;

  // request check results
  typedef struct packed {
    logic ent_ok;
    logic type_ok;
    logic full;
  } chk_t;

endpackage

[rtl/ect_intf.sv]
// channel interfaces of the entity component table engine
// depends on ect_pkg for field widths
interface ect_req_if #(parameter int DATA_WIDTH = 64);
  logic                         valid;
  logic                         ready;
  logic [ect_pkg::REQ_W-1:0]    req_type;
  logic [ect_pkg::ENT_W-1:0]    entity_index;
  logic [ect_pkg::TYPE_W-1:0]   type_index;
  logic [DATA_WIDTH-1:0]        payload_in;

  modport source (output valid, req_type, entity_index, type_index, payload_in, input ready);
  modport sink   (input valid, req_type, entity_index, type_index, payload_in, output ready);
endinterface

interface ect_rsp_if #(parameter int DATA_WIDTH = 64);
  logic                         valid;
  logic                         ready;
  logic [ect_pkg::STAT_W-1:0]   status;
  logic [ect_pkg::ENT_W-1:0]    entity_out;
  logic [ect_pkg::ENT_W-1:0]    slot_out;
  logic [DATA_WIDTH-1:0]        payload_out;
  logic [ect_pkg::MASK_W-1:0]   mask_out;
  logic [ect_pkg::CNT_W-1:0]    type_count;
  logic [ect_pkg::CNT_W-1:0]    live_entities;
  logic [ect_pkg::CNT_W-1:0]    index_bound;

  modport source (output valid, status, entity_out, slot_out, payload_out, mask_out,
                  type_count, live_entities, index_bound, input ready);
  modport sink   (input valid, status, entity_out, slot_out, payload_out, mask_out,
                  type_count, live_entities, index_bound, output ready);
endinterface

interface ect_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ect_pkg::CFGA_W-1:0]   index;
  logic [ect_pkg::CFGD_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/ect_req_check.sv]
// request checker: range checks, table-full test and live entity count
// depends on ect_pkg
module ect_req_check #(
  parameter int MAX_ENTITIES = 1024,
  parameter int MAX_TYPES    = 64
) (
  input  logic [ect_pkg::ENT_W-1:0]              entity_index_i,
  input  logic [ect_pkg::TYPE_W-1:0]             type_index_i,
  input  logic [ect_pkg::TIU_W-1:0]              types_in_use_i,
  input  logic [ect_pkg::LIM_W-1:0]              entity_limit_i,
  input  logic [$clog2(MAX_ENTITIES+1)-1:0]      fresh_i,
  input  logic [$clog2(MAX_ENTITIES+1)-1:0]      free_depth_i,
  output ect_pkg::chk_t                          chk_o,
  output logic [$clog2(MAX_ENTITIES+1)-1:0]      live_o
);
  localparam int CW = $clog2(MAX_ENTITIES + 1);
  localparam int XW = (CW > ect_pkg::LIM_W) ? CW : ect_pkg::LIM_W;

  logic [XW-1:0] lim;
  logic [XW-1:0] lim_raw;

  // effective limit is the smaller of the register and the table size
  assign lim_raw = XW'(entity_limit_i);
  assign lim     = (lim_raw > XW'(MAX_ENTITIES)) ? XW'(MAX_ENTITIES) : lim_raw;

  // live count saturates at zero
  assign live_o = (fresh_i > free_depth_i) ? (fresh_i - free_depth_i) : '0;

  always_comb begin
    chk_o.ent_ok  = XW'(entity_index_i) < lim;
    chk_o.type_ok = (type_index_i != '0)
                    && (ect_pkg::TIU_W'(type_index_i) < types_in_use_i)
                    && (ect_pkg::TIU_W'(type_index_i) < ect_pkg::TIU_W'(MAX_TYPES));
    chk_o.full    = (XW'(live_o) >= lim) || ((free_depth_i == '0) && (XW'(fresh_i) >= lim));
  end

endmodule

[rtl/entity_component_table_engine.sv]
// entity component table engine top level: sequencer, table memories, result register
// depends on ect_pkg, ect_intf (channel interfaces) and ect_req_check
//
//  channel | dir | beat carries
//  req_i   | in  | req_type, entity_index, type_index, payload_in
//  rsp_o   | out | status, entity_out, slot_out, payload_out, mask_out, counts
//  cfg_i   | in  | index, data (0 types_in_use, 1 entity_limit)
//
// after reset a clearing pass walks the slot table, one entry a cycle; no request is taken meanwhile
// the block returns to idle as the result is loaded into the output register
// remove shifts the dense data above the removed slot down one and rescans the slot table of
// that type to renumber its slots; delete walks the entity's mask bits and drops each component
// the same way, then releases the entity index
// one request is in flight at a time; a finished result waits in the output register
module entity_component_table_engine #(
  parameter int MAX_ENTITIES = 1024,
  parameter int MAX_TYPES    = 64,
  parameter int DATA_WIDTH   = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ect_req_if.sink  req_i,
  ect_rsp_if.source rsp_o,
  ect_cfg_if.sink  cfg_i
);
  localparam int EW = $clog2(MAX_ENTITIES);
  localparam int TW = $clog2(MAX_TYPES);
  localparam int CW = $clog2(MAX_ENTITIES + 1);
  localparam int AW = TW + EW;
  localparam int KW = TW + 1;
  localparam int MD = 2 ** EW;
  localparam int TD = 2 ** TW;
  localparam int CD = 2 ** AW;
  localparam int MT = MAX_TYPES;

  // sequencer states
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_POP   = 4'd3;
  localparam logic [3:0] S_DMASK = 4'd4;
  localparam logic [3:0] S_DSCAN = 4'd5;
  localparam logic [3:0] S_DRD   = 4'd6;
  localparam logic [3:0] S_DCHK  = 4'd7;
  localparam logic [3:0] S_SHIFT = 4'd8;
  localparam logic [3:0] S_REN   = 4'd9;
  localparam logic [3:0] S_DEND  = 4'd10;
  localparam logic [3:0] S_WBM   = 4'd11;
  localparam logic [3:0] S_LOOK  = 4'd12;
  localparam logic [3:0] S_GET   = 4'd13;
  localparam logic [3:0] S_FIN   = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  logic [3:0] state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [ect_pkg::TIU_W-1:0] types_q;
  logic [ect_pkg::LIM_W-1:0] limit_q;
  logic [CW-1:0] fresh_q, fresh_d, fd_q, fd_d;

  // latched request
  logic [ect_pkg::REQ_W-1:0]  r_type_q;
  logic [ect_pkg::ENT_W-1:0]  r_ent_q;
  logic [ect_pkg::TYPE_W-1:0] r_t_q;
  logic [DATA_WIDTH-1:0]      r_pay_q;

  // working registers
  logic [EW-1:0]  e_q, e_d;
  logic [MT-1:0]  m_q, m_d;
  logic [TW-1:0]  dt_q, dt_d;
  logic [KW-1:0]  k_q, k_d;
  logic [EW-1:0]  s_q, s_d;
  logic [CW-1:0]  n_q, n_d;
  logic [CW-1:0]  i_q, i_d;
  logic           pend_q, pend_d;
  logic [EW-1:0]  widx_q, widx_d;
  logic [ect_pkg::STAT_W-1:0] st_q, st_d;
  logic [EW-1:0]  so_q, so_d;
  logic [DATA_WIDTH-1:0] po_q, po_d;

  // result register
  logic                        rv_q;
  logic [ect_pkg::STAT_W-1:0]  r_status_q;
  logic [ect_pkg::ENT_W-1:0]   r_eout_q;
  logic [ect_pkg::ENT_W-1:0]   r_sout_q;
  logic [DATA_WIDTH-1:0]       r_pout_q;
  logic [ect_pkg::MASK_W-1:0]  r_mout_q;
  logic [ect_pkg::CNT_W-1:0]   r_cnt_q;
  logic [ect_pkg::CNT_W-1:0]   r_live_q;
  logic [ect_pkg::CNT_W-1:0]   r_bound_q;
  logic                        out_load;

  // memory ports
  logic [MT-1:0]         mask_mem [MD];
  logic                  mask_we;
  logic [EW-1:0]         mask_wa, mask_ra;
  logic [MT-1:0]         mask_wd, mask_rd;
  logic [EW:0]           slot_mem [CD];
  logic                  slot_we;
  logic [AW-1:0]         slot_wa, slot_ra;
  logic [EW:0]           slot_wd, slot_rd;
  logic [CW-1:0]         cnt_mem [TD];
  logic                  cnt_we;
  logic [TW-1:0]         cnt_wa, cnt_ra;
  logic [CW-1:0]         cnt_wd, cnt_rd;
  logic [DATA_WIDTH-1:0] pay_mem [CD];
  logic                  pay_we;
  logic [AW-1:0]         pay_wa, pay_ra;
  logic [DATA_WIDTH-1:0] pay_wd, pay_rd;
  logic [EW-1:0]         stk_mem [MD];
  logic                  stk_we;
  logic [EW-1:0]         stk_wa, stk_ra;
  logic [EW-1:0]         stk_wd, stk_rd;

  // helpers
  ect_pkg::chk_t chk;
  logic [CW-1:0] live;
  logic [EW-1:0] ent_e;
  logic [TW-1:0] t_e;
  logic          t_in;
  logic [CW-1:0] fd_dec;
  logic [CW-1:0] i_inc;
  logic          req_acc;

  assign ent_e   = EW'(r_ent_q);
  assign t_e     = r_t_q[TW-1:0];
  assign t_in    = ect_pkg::TIU_W'(r_t_q) < ect_pkg::TIU_W'(MAX_TYPES);
  assign fd_dec  = fd_q - CW'(1);
  assign i_inc   = i_q + CW'(1);
  assign req_acc = req_i.valid && req_i.ready;

  ect_req_check #(
    .MAX_ENTITIES (MAX_ENTITIES),
    .MAX_TYPES    (MAX_TYPES)
  ) u_check (
    .entity_index_i (r_ent_q),
    .type_index_i   (r_t_q),
    .types_in_use_i (types_q),
    .entity_limit_i (limit_q),
    .fresh_i        (fresh_q),
    .free_depth_i   (fd_q),
    .chk_o          (chk),
    .live_o         (live)
  );

  // channel handshakes
  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // sequencer
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    fresh_d = fresh_q;
    fd_d    = fd_q;
    e_d     = e_q;
    m_d     = m_q;
    dt_d    = dt_q;
    k_d     = k_q;
    s_d     = s_q;
    n_d     = n_q;
    i_d     = i_q;
    pend_d  = pend_q;
    widx_d  = widx_q;
    st_d    = st_q;
    so_d    = so_q;
    po_d    = po_q;
    out_load = 1'b0;

    mask_we = 1'b0;  mask_wa = ent_e;          mask_wd = '0;  mask_ra = ent_e;
    slot_we = 1'b0;  slot_wa = {dt_q, ent_e};  slot_wd = '0;  slot_ra = {dt_q, ent_e};
    cnt_we  = 1'b0;  cnt_wa  = t_e;            cnt_wd  = '0;  cnt_ra  = t_e;
    pay_we  = 1'b0;  pay_wa  = {dt_q, widx_q}; pay_wd  = pay_rd;
    pay_ra  = {dt_q, i_inc[EW-1:0]};
    stk_we  = 1'b0;  stk_wa  = fd_q[EW-1:0];   stk_wd  = ent_e; stk_ra = fd_dec[EW-1:0];

    unique case (state_q)
      // reset sweep over the slot table, masks and counts
      S_CLEAR: begin
        slot_we = 1'b1;
        slot_wa = clr_q;
        mask_we = 1'b1;
        mask_wa = clr_q[EW-1:0];
        cnt_we  = 1'b1;
        cnt_wa  = clr_q[TW-1:0];
        clr_d   = clr_q + AW'(1);
        if (clr_q == AW'(CD - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_acc) begin
          st_d    = ect_pkg::ST_OK;
          so_d    = '0;
          po_d    = '0;
          e_d     = '0;
          state_d = S_DEC;
        end
      end
      // decode and issue first reads
      S_DEC: begin
        case (r_type_q) inside
          ect_pkg::REQ_CREATE: begin
            if (chk.full) begin
              st_d    = ect_pkg::ST_FULL;
              state_d = S_FIN;
            end else if (fd_q != '0) begin
              fd_d    = fd_dec;
              state_d = S_POP;
            end else begin
              e_d     = fresh_q[EW-1:0];
              fresh_d = fresh_q + CW'(1);
              mask_we = 1'b1;
              mask_wa = fresh_q[EW-1:0];
              mask_wd = MT'(1);
              state_d = S_FIN;
            end
          end
          ect_pkg::REQ_DELETE: begin
            if (!chk.ent_ok) begin
              st_d    = ect_pkg::ST_RANGE;
              state_d = S_FIN;
            end else begin
              state_d = S_DMASK;
            end
          end
          ect_pkg::REQ_ADD, ect_pkg::REQ_REMOVE, ect_pkg::REQ_GET: begin
            if (!(chk.ent_ok && chk.type_ok)) begin
              st_d    = ect_pkg::ST_RANGE;
              state_d = S_FIN;
            end else begin
              slot_ra = {t_e, ent_e};
              dt_d    = t_e;
              state_d = S_LOOK;
            end
          end
          default: begin
            st_d    = ect_pkg::ST_RANGE;
            state_d = S_FIN;
          end
        endcase
      end
      // recycled entity from the free stack
      S_POP: begin
        e_d     = stk_rd;
        mask_we = 1'b1;
        mask_wa = stk_rd;
        mask_wd = MT'(1);
        state_d = S_FIN;
      end
      S_DMASK: begin
        if (mask_rd == '0) begin
          st_d    = ect_pkg::ST_ENT_ABSENT;
          state_d = S_FIN;
        end else begin
          m_d     = mask_rd;
          k_d     = KW'(1);
          state_d = S_DSCAN;
        end
      end
      // walk the mask bits of the entity being deleted
      S_DSCAN: begin
        if (k_q == KW'(MAX_TYPES)) begin
          state_d = S_DEND;
        end else if (m_q[k_q[TW-1:0]]) begin
          dt_d    = k_q[TW-1:0];
          state_d = S_DRD;
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      S_DRD: begin
        cnt_ra  = dt_q;
        state_d = S_DCHK;
      end
      // drop the component: free the slot, lower the count, clear the mask bit
      S_DCHK: begin
        if (!slot_rd[EW]) begin
          if (r_type_q == ect_pkg::REQ_DELETE) begin
            k_d     = k_q + KW'(1);
            state_d = S_DSCAN;
          end else begin
            state_d = S_WBM;
          end
        end else begin
          s_d     = slot_rd[EW-1:0];
          n_d     = cnt_rd;
          i_d     = CW'(slot_rd[EW-1:0]);
          pend_d  = 1'b0;
          slot_we = 1'b1;
          slot_wd = '0;
          cnt_we  = 1'b1;
          cnt_wa  = dt_q;
          cnt_wd  = (cnt_rd != '0) ? (cnt_rd - CW'(1)) : cnt_rd;
          m_d     = m_q & ~(MT'(1) << dt_q);
          state_d = S_SHIFT;
        end
      end
      // move the dense data down one slot, read one ahead of the write
      S_SHIFT: begin
        pay_we = pend_q;
        if ((i_inc < n_q) && (i_inc < CW'(MAX_ENTITIES))) begin
          pend_d = 1'b1;
          widx_d = i_q[EW-1:0];
          i_d    = i_inc;
        end else begin
          pend_d  = 1'b0;
          i_d     = '0;
          state_d = S_REN;
        end
      end
      // renumber the slots above the removed one
      S_REN: begin
        slot_wa = {dt_q, widx_q};
        slot_wd = {1'b1, slot_rd[EW-1:0] - EW'(1)};
        slot_we = pend_q && slot_rd[EW] && (slot_rd[EW-1:0] > s_q);
        if (i_q < CW'(MAX_ENTITIES)) begin
          slot_ra = {dt_q, i_q[EW-1:0]};
          pend_d  = 1'b1;
          widx_d  = i_q[EW-1:0];
          i_d     = i_inc;
        end else begin
          pend_d = 1'b0;
          if (r_type_q == ect_pkg::REQ_DELETE) begin
            k_d     = k_q + KW'(1);
            state_d = S_DSCAN;
          end else begin
            state_d = S_WBM;
          end
        end
      end
      // release the entity index
      S_DEND: begin
        mask_we = 1'b1;
        mask_wd = '0;
        if ((CW'(ent_e) + CW'(1)) == fresh_q) begin
          fresh_d = CW'(ent_e);
        end else if (fd_q < CW'(MAX_ENTITIES)) begin
          stk_we = 1'b1;
          fd_d   = fd_q + CW'(1);
        end
        state_d = S_FIN;
      end
      S_WBM: begin
        mask_we = 1'b1;
        mask_wd = m_q;
        state_d = S_FIN;
      end
      // slot lookup result for add, remove and get
      S_LOOK: begin
        case (r_type_q)
          ect_pkg::REQ_ADD: begin
            pay_we = 1'b1;
            pay_wd = r_pay_q;
            if (!slot_rd[EW]) begin
              slot_we = 1'b1;
              slot_wd = {1'b1, cnt_rd[EW-1:0]};
              cnt_we  = 1'b1;
              cnt_wd  = cnt_rd + CW'(1);
              mask_we = 1'b1;
              mask_wd = mask_rd | (MT'(1) << t_e);
              so_d    = cnt_rd[EW-1:0];
              pay_wa  = {t_e, cnt_rd[EW-1:0]};
            end else begin
              so_d    = slot_rd[EW-1:0];
              pay_wa  = {t_e, slot_rd[EW-1:0]};
            end
            state_d = S_FIN;
          end
          ect_pkg::REQ_REMOVE: begin
            if (!slot_rd[EW]) begin
              st_d    = ect_pkg::ST_COMP_ABSENT;
              state_d = S_FIN;
            end else begin
              m_d     = mask_rd;
              state_d = S_DRD;
            end
          end
          default: begin
            if (!slot_rd[EW]) begin
              st_d    = ect_pkg::ST_COMP_ABSENT;
              state_d = S_FIN;
            end else begin
              so_d    = slot_rd[EW-1:0];
              pay_ra  = {t_e, slot_rd[EW-1:0]};
              state_d = S_GET;
            end
          end
        endcase
      end
      S_GET: begin
        po_d    = pay_rd;
        state_d = S_FIN;
      end
      // mask and count read for the result
      S_FIN: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!rv_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      types_q <= ect_pkg::TIU_W'(1);
      limit_q <= ect_pkg::LIM_W'(1024);
      fresh_q <= '0;
      fd_q    <= '0;
      rv_q    <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      fresh_q <= fresh_d;
      fd_q    <= fd_d;
      pend_q  <= pend_d;
      if (out_load) begin
        rv_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rv_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        case (cfg_i.index)
          ect_pkg::CFG_TYPES_IN_USE: types_q <= cfg_i.data[ect_pkg::TIU_W-1:0];
          ect_pkg::CFG_ENTITY_LIMIT: limit_q <= cfg_i.data[ect_pkg::LIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      r_type_q <= req_i.req_type;
      r_ent_q  <= req_i.entity_index;
      r_t_q    <= req_i.type_index;
      r_pay_q  <= req_i.payload_in;
    end
    e_q    <= e_d;
    m_q    <= m_d;
    dt_q   <= dt_d;
    k_q    <= k_d;
    s_q    <= s_d;
    n_q    <= n_d;
    i_q    <= i_d;
    widx_q <= widx_d;
    st_q   <= st_d;
    so_q   <= so_d;
    po_q   <= po_d;
    if (out_load) begin
      r_status_q <= st_q;
      r_eout_q   <= (r_type_q == ect_pkg::REQ_CREATE) ? ect_pkg::ENT_W'(e_q) : r_ent_q;
      r_sout_q   <= ect_pkg::ENT_W'(so_q);
      r_pout_q   <= po_q;
      if (r_type_q == ect_pkg::REQ_CREATE) begin
        r_mout_q <= (st_q == ect_pkg::ST_OK) ? ect_pkg::MASK_W'(1) : '0;
      end else begin
        r_mout_q <= chk.ent_ok ? ect_pkg::MASK_W'(mask_rd) : '0;
      end
      r_cnt_q    <= t_in ? ect_pkg::CNT_W'(cnt_rd) : '0;
      r_live_q   <= ect_pkg::CNT_W'(live);
      r_bound_q  <= ect_pkg::CNT_W'(fresh_q);
    end
  end

  // entity masks
  always_ff @(posedge clk_i) begin
    if (mask_we) begin
      mask_mem[mask_wa] <= mask_wd;
    end
    mask_rd <= mask_mem[mask_ra];
  end

  // slot table, valid bit on top
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_rd <= slot_mem[slot_ra];
  end

  // per-type component counts
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_rd <= cnt_mem[cnt_ra];
  end

  // dense component data
  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      pay_mem[pay_wa] <= pay_wd;
    end
    pay_rd <= pay_mem[pay_ra];
  end

  // free entity stack
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_rd <= stk_mem[stk_ra];
  end

  // result beat
  assign rsp_o.valid         = rv_q;
  assign rsp_o.status        = r_status_q;
  assign rsp_o.entity_out    = r_eout_q;
  assign rsp_o.slot_out      = r_sout_q;
  assign rsp_o.payload_out   = r_pout_q;
  assign rsp_o.mask_out      = r_mout_q;
  assign rsp_o.type_count    = r_cnt_q;
  assign rsp_o.live_entities = r_live_q;
  assign rsp_o.index_bound   = r_bound_q;

endmodule
